// File: sv/tlb_rr_pkg.sv
// shared types, constants and functions of the random-replacement translation buffer
package tlb_rr_pkg;

    // default geometry
    localparam int TLB_ENTRIES_DEF = 16;
    localparam int VPAGE_BITS_DEF  = 18;
    localparam int PPAGE_BITS_DEF  = 16;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 19;
    localparam int LLIM_W     = 19;
    localparam int PLIM_W     = 17;
    localparam int SEED_W     = 16;

    localparam logic [LLIM_W-1:0] LLIM_RESET = LLIM_W'(262144);
    localparam logic [PLIM_W-1:0] PLIM_RESET = PLIM_W'(65536);
    localparam logic [SEED_W-1:0] SEED_RESET = SEED_W'(1);

    // galois lfsr feedback mask
    localparam logic [SEED_W-1:0] LFSR_TAPS = 16'hB400;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOGICAL_LIMIT  = 2'd0,
        CFG_PHYSICAL_LIMIT = 2'd1,
        CFG_REPLACE_SEED   = 2'd2
    } t_cfg_index;

    // commands
    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_DELETE = 2'd2
    } t_command;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_MISS     = 3'd1,
        ST_INVALID  = 3'd2,
        ST_DUP      = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    // entry array update request
    typedef struct packed {
        logic wr_en;
        logic clr_en;
    } t_array_ctl;

    // entry array search flags
    typedef struct packed {
        logic tag_hit;
        logic free_found;
        logic frame_hit;
    } t_array_flags;

    // one step of the replacement lfsr
    function automatic logic [SEED_W-1:0] lfsr_next(input logic [SEED_W-1:0] v);
        logic [SEED_W-1:0] s;
        s = v >> 1;
        if (v[0]) begin
            s = s ^ LFSR_TAPS;
        end
        return s;
    endfunction

    // zero seed would lock the lfsr
    function automatic logic [SEED_W-1:0] seed_fix(input logic [SEED_W-1:0] v);
        return (v == '0) ? SEED_W'(1) : v;
    endfunction

endpackage

// File: sv/tlb_rr_lfsr.sv
// replacement lfsr and the victim slot it picks
module tlb_rr_lfsr #(
    parameter int TLB_ENTRIES = tlb_rr_pkg::TLB_ENTRIES_DEF,
    localparam int SLOT_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_seed_load,
    input  logic [tlb_rr_pkg::SEED_W-1:0] i_seed,
    input  logic                          i_step,
    output logic [SLOT_W-1:0]             o_pick
);

    localparam int NIBBLES = tlb_rr_pkg::SEED_W / 4;
    localparam int SUM_W   = SLOT_W + 2;
    localparam logic [SUM_W-1:0] ONE_N = SUM_W'(TLB_ENTRIES);
    localparam logic [SUM_W-1:0] TWO_N = SUM_W'(2 * TLB_ENTRIES);

    logic [tlb_rr_pkg::SEED_W-1:0] r_lfsr;
    logic [tlb_rr_pkg::SEED_W-1:0] n_lfsr;
    logic [tlb_rr_pkg::SEED_W-1:0] stepped;
    logic [NIBBLES-1:0][SLOT_W-1:0] part;
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] red;

    assign stepped = tlb_rr_pkg::lfsr_next(r_lfsr);

    // residue of each nibble from a constant table
    for (genvar k = 0; k < NIBBLES; k++) begin : g_nib
        logic [15:0][SLOT_W-1:0] cand;
        for (genvar n = 0; n < 16; n++) begin : g_val
            localparam int RES = (n * (16 ** k)) % TLB_ENTRIES;
            assign cand[n] = SLOT_W'(RES);
        end
        assign part[k] = cand[stepped[4*k +: 4]];
    end

    // add residues, then fold below the entry count
    always_comb begin
        sum = '0;
        for (int k = 0; k < NIBBLES; k++) begin
            sum = sum + SUM_W'(part[k]);
        end
        red = (sum >= TWO_N) ? (sum - TWO_N) : sum;
        red = (red >= ONE_N) ? (red - ONE_N) : red;
    end

    assign o_pick = red[SLOT_W-1:0];

    // seed load wins over a step
    always_comb begin
        n_lfsr = r_lfsr;
        if (i_seed_load) begin
            n_lfsr = tlb_rr_pkg::seed_fix(i_seed);
        end else if (i_step) begin
            n_lfsr = stepped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= tlb_rr_pkg::seed_fix(tlb_rr_pkg::SEED_RESET);
        end else begin
            r_lfsr <= n_lfsr;
        end
    end

endmodule

// File: sv/tlb_rr_array.sv
// entry storage with parallel tag and frame compare
module tlb_rr_array #(
    parameter int TLB_ENTRIES = tlb_rr_pkg::TLB_ENTRIES_DEF,
    parameter int VPAGE_BITS  = tlb_rr_pkg::VPAGE_BITS_DEF,
    parameter int PPAGE_BITS  = tlb_rr_pkg::PPAGE_BITS_DEF,
    localparam int SLOT_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [VPAGE_BITS-1:0]    i_vp,
    input  logic [PPAGE_BITS-1:0]    i_pp,
    input  tlb_rr_pkg::t_array_ctl   i_ctl,
    input  logic [SLOT_W-1:0]        i_wr_idx,
    output tlb_rr_pkg::t_array_flags o_flags,
    output logic [PPAGE_BITS-1:0]    o_hit_frame,
    output logic [SLOT_W-1:0]        o_free_idx,
    output logic [SLOT_W-1:0]        o_frame_idx
);

    logic [TLB_ENTRIES-1:0]                 r_valid;
    logic [TLB_ENTRIES-1:0][VPAGE_BITS-1:0] r_tag;
    logic [TLB_ENTRIES-1:0][PPAGE_BITS-1:0] r_frame;

    logic [TLB_ENTRIES-1:0] tag_match;
    logic [TLB_ENTRIES-1:0] frame_match;
    logic [TLB_ENTRIES-1:0] tag_first;
    logic [TLB_ENTRIES-1:0] tag_seen;

    // per-entry compares
    always_comb begin
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            tag_match[i]   = r_valid[i] && (r_tag[i] == i_vp);
            frame_match[i] = r_valid[i] && (r_frame[i] == i_pp);
        end
    end

    // lowest matching tag as a one-hot
    always_comb begin
        tag_seen[0]  = tag_match[0];
        tag_first[0] = tag_match[0];
        for (int i = 1; i < TLB_ENTRIES; i++) begin
            tag_first[i] = tag_match[i] && !tag_seen[i-1];
            tag_seen[i]  = tag_match[i] || tag_seen[i-1];
        end
    end

    // frame of the hit entry
    always_comb begin
        o_hit_frame = '0;
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            o_hit_frame = o_hit_frame | (tag_first[i] ? r_frame[i] : '0);
        end
    end

    // lowest free slot and lowest frame match
    always_comb begin
        o_free_idx  = '0;
        o_frame_idx = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                o_free_idx = SLOT_W'(i);
            end
            if (frame_match[i]) begin
                o_frame_idx = SLOT_W'(i);
            end
        end
    end

    assign o_flags.tag_hit    = |tag_match;
    assign o_flags.free_found = ~&r_valid;
    assign o_flags.frame_hit  = |frame_match;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_ctl.wr_en) begin
                r_valid[i_wr_idx] <= 1'b1;
            end
            if (i_ctl.clr_en) begin
                r_valid[o_frame_idx] <= 1'b0;
            end
        end
    end

    // tag and frame payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_tag[i_wr_idx]   <= i_vp;
            r_frame[i_wr_idx] <= i_pp;
        end
    end

endmodule

// File: sv/tlb_random_replacement_top.sv
// top level of the fully associative translation buffer with random replacement
//
//  port group       dir  handshake                 contents
//  command          in   i_start, o_busy           i_command, i_virt_page, i_phys_page
//  result           out  o_done (one cycle)        o_status, o_found_page, o_slot,
//                                                  o_hits_total, o_misses_total,
//                                                  o_used_entries
//  configuration    in   i_cfg_we                  i_cfg_index, i_cfg_data
//
// one item is taken every cycle; o_busy stays low
// the item lands in the input register; the parallel compare of all entries and
// the update feed the result register, which drives o_done together with the
// result outputs
// synchronous active-low reset clears valid bits and counters, restores the limits
// and loads the lfsr with its reset seed
// the receiver cannot stall, so a result is lost if it is not taken on o_done
module tlb_random_replacement_top #(
    parameter int TLB_ENTRIES = tlb_rr_pkg::TLB_ENTRIES_DEF,
    parameter int VPAGE_BITS  = tlb_rr_pkg::VPAGE_BITS_DEF,
    parameter int PPAGE_BITS  = tlb_rr_pkg::PPAGE_BITS_DEF,
    localparam int SLOT_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1,
    localparam int USED_W = $clog2(TLB_ENTRIES + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic [1:0]                        i_command,
    input  logic [VPAGE_BITS-1:0]             i_virt_page,
    input  logic [PPAGE_BITS-1:0]             i_phys_page,
    input  logic                              i_cfg_we,
    input  logic [tlb_rr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tlb_rr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                              o_done,
    output logic [2:0]                        o_status,
    output logic [PPAGE_BITS-1:0]             o_found_page,
    output logic [SLOT_W-1:0]                 o_slot,
    output logic [31:0]                       o_hits_total,
    output logic [31:0]                       o_misses_total,
    output logic [USED_W-1:0]                 o_used_entries
);

    localparam int VCMP_W = (VPAGE_BITS > tlb_rr_pkg::LLIM_W) ? VPAGE_BITS : tlb_rr_pkg::LLIM_W;
    localparam int PCMP_W = (PPAGE_BITS > tlb_rr_pkg::PLIM_W) ? PPAGE_BITS : tlb_rr_pkg::PLIM_W;

    // configuration registers
    logic [tlb_rr_pkg::LLIM_W-1:0] r_llim;
    logic [tlb_rr_pkg::PLIM_W-1:0] r_plim;
    logic                          seed_load;

    // input register
    logic                 r_req_valid;
    tlb_rr_pkg::t_command r_cmd;
    logic [VPAGE_BITS-1:0] r_vp;
    logic [PPAGE_BITS-1:0] r_pp;

    // state counters
    logic [31:0]       r_hits;
    logic [31:0]       r_misses;
    logic [USED_W-1:0] r_used;
    logic [31:0]       n_hits;
    logic [31:0]       n_misses;
    logic [USED_W-1:0] n_used;

    // result register
    logic                  r_done;
    tlb_rr_pkg::t_status   r_status;
    logic [PPAGE_BITS-1:0] r_found;
    logic [SLOT_W-1:0]     r_slot;
    tlb_rr_pkg::t_status   n_status;
    logic [PPAGE_BITS-1:0] n_found;
    logic [SLOT_W-1:0]     n_slot;

    // array and lfsr hookup
    tlb_rr_pkg::t_array_ctl   arr_ctl;
    tlb_rr_pkg::t_array_flags arr_flags;
    logic [PPAGE_BITS-1:0]    hit_frame;
    logic [SLOT_W-1:0]        free_idx;
    logic [SLOT_W-1:0]        frame_idx;
    logic [SLOT_W-1:0]        wr_idx;
    logic [SLOT_W-1:0]        pick;
    logic                     lfsr_step;
    logic                     vp_ok;
    logic                     pp_ok;

    assign o_busy = 1'b0;

    // configuration writes
    assign seed_load = i_cfg_we &&
                       (i_cfg_index == tlb_rr_pkg::CFG_REPLACE_SEED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_llim <= tlb_rr_pkg::LLIM_RESET;
            r_plim <= tlb_rr_pkg::PLIM_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == tlb_rr_pkg::CFG_LOGICAL_LIMIT) begin
                r_llim <= i_cfg_data[tlb_rr_pkg::LLIM_W-1:0];
            end
            if (i_cfg_index == tlb_rr_pkg::CFG_PHYSICAL_LIMIT) begin
                r_plim <= i_cfg_data[tlb_rr_pkg::PLIM_W-1:0];
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else begin
            r_req_valid <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cmd <= tlb_rr_pkg::t_command'(i_command);
            r_vp  <= i_virt_page;
            r_pp  <= i_phys_page;
        end
    end

    // page range checks
    assign vp_ok = VCMP_W'(r_vp) < VCMP_W'(r_llim);
    assign pp_ok = PCMP_W'(r_pp) < PCMP_W'(r_plim);

    tlb_rr_array #(
        .TLB_ENTRIES (TLB_ENTRIES),
        .VPAGE_BITS  (VPAGE_BITS),
        .PPAGE_BITS  (PPAGE_BITS)
    ) u_array (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vp        (r_vp),
        .i_pp        (r_pp),
        .i_ctl       (arr_ctl),
        .i_wr_idx    (wr_idx),
        .o_flags     (arr_flags),
        .o_hit_frame (hit_frame),
        .o_free_idx  (free_idx),
        .o_frame_idx (frame_idx)
    );

    tlb_rr_lfsr #(
        .TLB_ENTRIES (TLB_ENTRIES)
    ) u_lfsr (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seed_load (seed_load),
        .i_seed      (i_cfg_data[tlb_rr_pkg::SEED_W-1:0]),
        .i_step      (lfsr_step),
        .o_pick      (pick)
    );

    assign wr_idx = arr_flags.free_found ? free_idx : pick;

    // command decode and state update
    always_comb begin
        n_status       = tlb_rr_pkg::ST_OK;
        n_found        = '0;
        n_slot         = '0;
        n_hits         = r_hits;
        n_misses       = r_misses;
        n_used         = r_used;
        arr_ctl.wr_en  = 1'b0;
        arr_ctl.clr_en = 1'b0;
        lfsr_step      = 1'b0;
        if (r_req_valid) begin
            case (r_cmd)
                tlb_rr_pkg::CMD_LOOKUP: begin
                    if (!vp_ok) begin
                        n_status = tlb_rr_pkg::ST_INVALID;
                    end else if (arr_flags.tag_hit) begin
                        n_found = hit_frame;
                        n_hits  = r_hits + 32'd1;
                    end else begin
                        n_status = tlb_rr_pkg::ST_MISS;
                        n_misses = r_misses + 32'd1;
                    end
                end
                tlb_rr_pkg::CMD_ADD: begin
                    if (!vp_ok || !pp_ok) begin
                        n_status = tlb_rr_pkg::ST_INVALID;
                    end else if (arr_flags.tag_hit) begin
                        n_status = tlb_rr_pkg::ST_DUP;
                    end else begin
                        arr_ctl.wr_en = 1'b1;
                        n_slot        = wr_idx;
                        if (arr_flags.free_found) begin
                            n_used = r_used + USED_W'(1);
                        end else begin
                            lfsr_step = 1'b1;
                        end
                    end
                end
                tlb_rr_pkg::CMD_DELETE: begin
                    if (!pp_ok) begin
                        n_status = tlb_rr_pkg::ST_INVALID;
                    end else if (arr_flags.frame_hit) begin
                        arr_ctl.clr_en = 1'b1;
                        n_slot         = frame_idx;
                        n_used         = r_used - USED_W'(1);
                    end else begin
                        n_status = tlb_rr_pkg::ST_NOTFOUND;
                    end
                end
                default: begin
                    n_status = tlb_rr_pkg::ST_OK;
                end
            endcase
        end
    end

    // counters and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits   <= '0;
            r_misses <= '0;
            r_used   <= '0;
            r_done   <= 1'b0;
        end else begin
            r_hits   <= n_hits;
            r_misses <= n_misses;
            r_used   <= n_used;
            r_done   <= r_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_req_valid) begin
            r_status <= n_status;
            r_found  <= n_found;
            r_slot   <= n_slot;
        end
    end

    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_found_page   = r_found;
    assign o_slot         = r_slot;
    assign o_hits_total   = r_hits;
    assign o_misses_total = r_misses;
    assign o_used_entries = r_used;

endmodule
